>>> sv/tlv_frame_crc_parser_unit_macros.svh
// -----------------------------------------------------------------------------
// TLV frame CRC parser - assertion macros
// Concurrent checks clocked on clk and disabled during reset.
// -----------------------------------------------------------------------------
`ifndef TLV_FRAME_CRC_PARSER_UNIT_MACROS_SVH
`define TLV_FRAME_CRC_PARSER_UNIT_MACROS_SVH

`ifndef SYNTH
`define TFCP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);
`define TFCP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define TFCP_ASSERT_IMP(label, ante, cons, msg)
`define TFCP_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

>>> sv/tfcp_pkg.sv
// -----------------------------------------------------------------------------
// TLV frame CRC parser - package
// Constants, controller/datapath interface types and the CRC byte step.
// -----------------------------------------------------------------------------
package tfcp_pkg;

	localparam logic [7:0]  HDR_BYTE  = 8'hFF;
	localparam logic [7:0]  FIXED_LEN = 8'd5;
	localparam logic [15:0] CRC_POLY  = 16'h1021;

	localparam logic [1:0] REG_CRC_SEED      = 2'd0;
	localparam logic [1:0] REG_ACCEPTED_TAG  = 2'd1;
	localparam logic [1:0] REG_MAX_VALUE_LEN = 2'd2;

	localparam logic [15:0] CRC_SEED_RST      = 16'hFFFF;
	localparam logic [7:0]  ACCEPTED_TAG_RST  = 8'd3;
	localparam logic [5:0]  MAX_VALUE_LEN_RST = 6'd11;

	typedef struct packed {
		logic hdr;
		logic tag;
		logic len;
		logic body;
		logic rd_first;
		logic rd_next;
		logic load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_hdr;
		logic len_bad;
		logic frame_end;
		logic crc_ok;
		logic emit_more;
		logic out_free;
	} dp_sts_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

>>> sv/tlv_frame_crc_parser_unit.sv
// -----------------------------------------------------------------------------
// TLV frame CRC parser - top level
// Hunts for 0xFF headers, captures TLV frames, checks CRC-16/ITU-T and
// replays verified frames byte by byte.
// -----------------------------------------------------------------------------
// Input stream: one received byte per item on s_tdata. Bytes are taken one per
// cycle while hunting or capturing a frame.
// Output stream: each byte of a CRC-verified frame on m_tdata, header first,
// with m_tlast on the final CRC byte and m_tuser set when the tag equals
// accepted_tag. A frame that fails the length or CRC check gives no output.
// Emission: after the final CRC byte is accepted the controller passes through
// ST_EMIT_RD (frame store read) and ST_EMIT_WR, which loads the output register
// that drives m_tvalid. Emission runs at one byte per cycle while the receiver
// is ready, out of the frame store (one RAM read port); s_tready is low during
// emission, so input is blocked while a frame replays.
// A stalled receiver holds the output register and pauses the replay; after
// the last byte is loaded, input resumes even while that byte still waits.
// Reset clears the parser to hunting, empties the output register and loads
// the register defaults (crc_seed 0xFFFF, accepted_tag 3, max_value_len 11).
// Configuration: APB, registers at 0x0, 0x4, 0x8; write only while idle.
// -----------------------------------------------------------------------------
module tlv_frame_crc_parser_unit #(
	parameter int MAX_FRAME = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] frame_byte
	output logic        m_tlast,
	output logic        m_tuser,   // [0] tag_match
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	import tfcp_pkg::*;

	`include "tlv_frame_crc_parser_unit_macros.svh"

	logic [15:0] crc_seed_q;
	logic [7:0]  accepted_tag_q;
	logic [5:0]  max_value_len_q;
	logic [1:0]  reg_idx;
	logic        cfg_wr;
	ctrl_cmd_t   cmd;
	dp_sts_t     sts;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_seed_q      <= CRC_SEED_RST;
			accepted_tag_q  <= ACCEPTED_TAG_RST;
			max_value_len_q <= MAX_VALUE_LEN_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_CRC_SEED:      crc_seed_q      <= pwdata[15:0];
				REG_ACCEPTED_TAG:  accepted_tag_q  <= pwdata[7:0];
				REG_MAX_VALUE_LEN: max_value_len_q <= pwdata[5:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_CRC_SEED:      prdata = {16'h0000, crc_seed_q};
			REG_ACCEPTED_TAG:  prdata = {24'h000000, accepted_tag_q};
			REG_MAX_VALUE_LEN: prdata = {26'h0000000, max_value_len_q};
			default:           prdata = '0;
		endcase
	end

	tfcp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tfcp_dp #(
		.MAX_FRAME (MAX_FRAME)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.rx_byte       (s_tdata),
		.crc_seed      (crc_seed_q),
		.accepted_tag  (accepted_tag_q),
		.max_value_len (max_value_len_q),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.frame_byte    (m_tdata),
		.frame_last    (m_tlast),
		.tag_match     (m_tuser)
	);

	`TFCP_ASSERT_NXT(a_resume_after_last, cmd.load && !sts.emit_more, s_tready, "no resume after last byte")
	`TFCP_ASSERT_IMP(a_first_not_last, $rose(m_tvalid), !m_tlast, "frame starts on a last byte")
	`TFCP_ASSERT_IMP(a_load_blocks_input, cmd.load, !s_tready, "input open during replay")

endmodule

>>> sv/tfcp_ram.sv
// -----------------------------------------------------------------------------
// TLV frame CRC parser - generic RAM
// One write port, one read port with registered read data.
// -----------------------------------------------------------------------------
module tfcp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/tfcp_ctrl.sv
// -----------------------------------------------------------------------------
// TLV frame CRC parser - controller
// Sequences header hunt, frame capture and emission of verified frames.
// -----------------------------------------------------------------------------
module tfcp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  tfcp_pkg::dp_sts_t    sts,
	output tfcp_pkg::ctrl_cmd_t  cmd
);

	import tfcp_pkg::*;

	typedef enum logic [2:0] {
		ST_HUNT,
		ST_TAG,
		ST_LEN,
		ST_BODY,
		ST_EMIT_RD,
		ST_EMIT_WR
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   fire;

	assign s_tready = (state_q == ST_HUNT) || (state_q == ST_TAG) ||
	                  (state_q == ST_LEN)  || (state_q == ST_BODY);
	assign fire = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_HUNT: begin
				if (fire && sts.is_hdr) begin
					cmd.hdr = 1'b1;
					state_d = ST_TAG;
				end
			end
			ST_TAG: begin
				if (fire) begin
					cmd.tag = 1'b1;
					state_d = ST_LEN;
				end
			end
			ST_LEN: begin
				if (fire) begin
					if (sts.len_bad) begin
						state_d = ST_HUNT;
					end else begin
						cmd.len = 1'b1;
						state_d = ST_BODY;
					end
				end
			end
			ST_BODY: begin
				if (fire) begin
					cmd.body = 1'b1;
					if (sts.frame_end) begin
						state_d = sts.crc_ok ? ST_EMIT_RD : ST_HUNT;
					end
				end
			end
			ST_EMIT_RD: begin
				cmd.rd_first = 1'b1;
				state_d      = ST_EMIT_WR;
			end
			ST_EMIT_WR: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					if (sts.emit_more) begin
						cmd.rd_next = 1'b1;
					end else begin
						state_d = ST_HUNT;
					end
				end
			end
			default: begin
				state_d = ST_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> sv/tfcp_dp.sv
// -----------------------------------------------------------------------------
// TLV frame CRC parser - datapath
// Byte counter, length check, running CRC, frame store and output register.
// -----------------------------------------------------------------------------
module tfcp_dp #(
	parameter int MAX_FRAME = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tfcp_pkg::ctrl_cmd_t  cmd,
	output tfcp_pkg::dp_sts_t    sts,
	input  logic [7:0]           rx_byte,
	input  logic [15:0]          crc_seed,
	input  logic [7:0]           accepted_tag,
	input  logic [5:0]           max_value_len,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           frame_byte,
	output logic                 frame_last,
	output logic                 tag_match
);

	import tfcp_pkg::*;

	localparam int CW = $clog2(MAX_FRAME + 1);
	localparam int AW = $clog2(MAX_FRAME);
	localparam logic [7:0] LEN_MAX = 8'(MAX_FRAME);

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] len_q;
	logic [CW-1:0] emit_idx_q;
	logic [15:0]   crc_q;
	logic [7:0]    crc_hi_q;
	logic [7:0]    tag_q;
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          out_last_q;
	logic          out_tag_q;

	logic [CW:0]   cnt_p1;
	logic [CW:0]   cnt_p2;
	logic [CW:0]   emit_p1;
	logic [CW-1:0] emit_nxt;
	logic [15:0]   crc_in;
	logic [15:0]   crc_nxt;
	logic          store_we;
	logic [AW-1:0] store_waddr;
	logic          store_re;
	logic [AW-1:0] store_raddr;
	logic [7:0]    store_rdata;

	assign cnt_p1   = {1'b0, cnt_q} + (CW+1)'(1);
	assign cnt_p2   = {1'b0, cnt_q} + (CW+1)'(2);
	assign emit_p1  = {1'b0, emit_idx_q} + (CW+1)'(1);
	assign emit_nxt = emit_p1[CW-1:0];

	assign crc_in  = cmd.hdr ? crc_seed : crc_q;
	assign crc_nxt = crc_byte(crc_in, rx_byte);

	assign sts.is_hdr    = (rx_byte == HDR_BYTE);
	assign sts.len_bad   = (rx_byte < FIXED_LEN) ||
	                       ((rx_byte - FIXED_LEN) > {2'b00, max_value_len}) ||
	                       (rx_byte > LEN_MAX);
	assign sts.frame_end = (cnt_p1 == {1'b0, len_q});
	assign sts.crc_ok    = ({crc_hi_q, rx_byte} == crc_q);
	assign sts.emit_more = (emit_p1 < {1'b0, len_q});
	assign sts.out_free  = !out_valid_q || out_ready;

	assign store_we    = cmd.hdr || cmd.tag || cmd.len || cmd.body;
	assign store_waddr = cmd.hdr ? '0 : cnt_q[AW-1:0];
	assign store_re    = cmd.rd_first || cmd.rd_next;
	assign store_raddr = cmd.rd_first ? '0 : emit_nxt[AW-1:0];

	tfcp_ram #(
		.WIDTH (8),
		.DEPTH (MAX_FRAME)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (store_waddr),
		.wdata (rx_byte),
		.re    (store_re),
		.raddr (store_raddr),
		.rdata (store_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			crc_q       <= CRC_SEED_RST;
			out_valid_q <= 1'b0;
			emit_idx_q  <= '0;
		end else begin
			if (cmd.hdr) begin
				cnt_q <= CW'(1);
			end else if (cmd.tag || cmd.len || cmd.body) begin
				cnt_q <= cnt_p1[CW-1:0];
			end
			if (cmd.hdr || cmd.tag || cmd.len || (cmd.body && (cnt_p2 < {1'b0, len_q}))) begin
				crc_q <= crc_nxt;
			end
			if (cmd.rd_first) begin
				emit_idx_q <= '0;
			end else if (cmd.rd_next) begin
				emit_idx_q <= emit_nxt;
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tag) begin
			tag_q <= rx_byte;
		end
		if (cmd.len) begin
			len_q <= rx_byte[CW-1:0];
		end
		if (cmd.body && (cnt_p2 == {1'b0, len_q})) begin
			crc_hi_q <= rx_byte;
		end
		if (cmd.load) begin
			out_byte_q <= store_rdata;
			out_last_q <= !sts.emit_more;
			out_tag_q  <= (tag_q == accepted_tag);
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_byte = out_byte_q;
	assign frame_last = out_last_q;
	assign tag_match  = out_tag_q;

endmodule

>>> verif/tlv_frame_crc_parser_unit_test.sv
// -----------------------------------------------------------------------------
// TLV frame CRC parser - unit testbench
// Drives received bytes into the parser, models the hunting, length and
// CRC-16/ITU-T checks on the side and compares every replayed frame byte, its
// last mark and its tag flag against the modeled frame. Directed frames cover
// the corner cases, random frame streams under several register settings and
// random stalls on both sides cover the rest.
// -----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tlv_frame_crc_parser_unit_test;

	import tfcp_pkg::*;

	localparam int STORE_DEPTH  = 16;
	localparam int LIMIT_CYCLES = 200000;
	localparam int SETTLE_WAIT  = 24;

	typedef enum logic [1:0] {RX_HUNT, RX_TAG, RX_LEN, RX_BODY} rx_phase_t;
	typedef enum int {FRAME_OK, FRAME_BAD_CRC, FRAME_CUT} frame_fault_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       tag_hit;
	} frame_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;   // [7:0] rx_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;           // [7:0] frame_byte
	logic        m_tlast;
	logic        m_tuser;           // [0] tag_match
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = 4'h0;
	logic [31:0] pwdata = 32'h0;
	logic [31:0] prdata;
	logic        pready;

	// register copies
	logic [15:0] seed_cfg = CRC_SEED_RST;
	logic [7:0]  tag_cfg  = ACCEPTED_TAG_RST;
	logic [5:0]  maxv_cfg = MAX_VALUE_LEN_RST;

	// parser model state
	rx_phase_t   rx_phase = RX_HUNT;
	logic [7:0]  rx_store [0:STORE_DEPTH-1];
	int          rx_held = 0;
	int          rx_len = 0;
	logic [15:0] rx_crc = CRC_SEED_RST;

	frame_item_t replay_q [$];
	int          fail_count = 0;
	int          cycle_count = 0;
	bit          src_gaps_on = 1'b1;
	bit          sink_gaps_on = 1'b1;
	int          sink_hold = 0;
	int          sink_stall = 0;

	tlv_frame_crc_parser_unit #(.MAX_FRAME(STORE_DEPTH)) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("tlv_frame_crc_parser_unit verification failed");
			$finish;
		end
	end

	function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] din);
		logic [15:0] r;
		int          k;
		r = acc;
		for (k = 0; k < 8; k++) begin
			if (r[15] ^ din[7-k])
				r = {r[14:0], 1'b0} ^ CRC_POLY;
			else
				r = {r[14:0], 1'b0};
		end
		return r;
	endfunction

	function automatic void hold_rx_byte(input logic [7:0] b);
		if (rx_held < STORE_DEPTH)
			rx_store[rx_held] = b;
		rx_held++;
	endfunction

	function automatic void predict_rx_byte(input logic [7:0] b);
		frame_item_t item;
		int          i;
		case (rx_phase)
			RX_HUNT: begin
				if (b == HDR_BYTE) begin
					rx_held = 0;
					hold_rx_byte(b);
					rx_crc = crc16_step(seed_cfg, b);
					rx_phase = RX_TAG;
				end
			end
			RX_TAG: begin
				hold_rx_byte(b);
				rx_crc = crc16_step(rx_crc, b);
				rx_phase = RX_LEN;
			end
			RX_LEN: begin
				if (b < FIXED_LEN || int'(b) - int'(FIXED_LEN) > int'(maxv_cfg)
						|| int'(b) > STORE_DEPTH) begin
					rx_phase = RX_HUNT;
					rx_held = 0;
				end else begin
					hold_rx_byte(b);
					rx_len = b;
					rx_crc = crc16_step(rx_crc, b);
					rx_phase = RX_BODY;
				end
			end
			default: begin
				hold_rx_byte(b);
				if (rx_held <= rx_len - 2)
					rx_crc = crc16_step(rx_crc, b);
				if (rx_held >= rx_len) begin
					if ({rx_store[rx_len-2], rx_store[rx_len-1]} == rx_crc) begin
						for (i = 0; i < rx_len; i++) begin
							item.data = rx_store[i];
							item.last = (i == rx_len - 1);
							item.tag_hit = (rx_store[1] == tag_cfg);
							replay_q.push_back(item);
						end
					end
					rx_phase = RX_HUNT;
					rx_held = 0;
				end
			end
		endcase
	endfunction

	always @(posedge clk) begin : frame_check
		frame_item_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				predict_rx_byte(s_tdata);
			if (m_tvalid && m_tready) begin
				if (replay_q.size() == 0) begin
					$error("unexpected item: frame_byte %02h tlast %0b tuser %0b",
						m_tdata, m_tlast, m_tuser);
					fail_count++;
				end else begin
					want = replay_q.pop_front();
					if (m_tdata !== want.data) begin
						$error("frame_byte expected %02h got %02h", want.data, m_tdata);
						fail_count++;
					end
					if (m_tlast !== want.last) begin
						$error("frame_last expected %0b got %0b", want.last, m_tlast);
						fail_count++;
					end
					if (m_tuser !== want.tag_hit) begin
						$error("tag_match expected %0b got %0b", want.tag_hit, m_tuser);
						fail_count++;
					end
				end
			end
		end
	end

	initial begin : sink_ready
		forever begin
			@(posedge clk);
			if (sink_hold > 0) begin
				sink_hold--;
				m_tready <= 1'b0;
			end else if (sink_stall > 0) begin
				sink_stall--;
				m_tready <= 1'b0;
			end else if (sink_gaps_on && $urandom_range(0, 4) == 0) begin
				sink_stall = $urandom_range(1, 14) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_rx_byte(input logic [7:0] b);
		if (src_gaps_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (replay_q.size() != 0) @(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] reg_idx, input logic [31:0] value);
		settle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (reg_idx)
			REG_CRC_SEED:      seed_cfg = value[15:0];
			REG_ACCEPTED_TAG:  tag_cfg = value[7:0];
			REG_MAX_VALUE_LEN: maxv_cfg = value[5:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [15:0] seed, input logic [7:0] tag,
			input logic [5:0] maxv);
		write_reg(REG_CRC_SEED, {16'h0, seed});
		write_reg(REG_ACCEPTED_TAG, {24'h0, tag});
		write_reg(REG_MAX_VALUE_LEN, {26'h0, maxv});
	endtask

	task automatic send_frame(input logic [7:0] tag, input int len, input frame_fault_t fault,
			input bit ff_value);
		logic [7:0]  fb [0:STORE_DEPTH-1];
		logic [15:0] crc;
		int          i;
		int          n_send;
		fb[0] = HDR_BYTE;
		fb[1] = tag;
		fb[2] = len[7:0];
		crc = crc16_step(seed_cfg, fb[0]);
		crc = crc16_step(crc, fb[1]);
		crc = crc16_step(crc, fb[2]);
		for (i = 3; i < len - 2; i++) begin
			fb[i] = (ff_value && i == 3) ? HDR_BYTE : 8'($urandom);
			crc = crc16_step(crc, fb[i]);
		end
		if (fault == FRAME_BAD_CRC)
			crc = crc ^ (16'h1 << $urandom_range(0, 15));
		fb[len-2] = crc[15:8];
		fb[len-1] = crc[7:0];
		n_send = (fault == FRAME_CUT) ? $urandom_range(3, len - 1) : len;
		for (i = 0; i < n_send; i++)
			send_rx_byte(fb[i]);
	endtask

	task automatic send_bad_length(input logic [7:0] tag, input logic [7:0] len);
		send_rx_byte(HDR_BYTE);
		send_rx_byte(tag);
		send_rx_byte(len);
	endtask

	task automatic flush_parser();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (rx_phase != RX_HUNT) begin
			send_rx_byte(8'h00);
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic test_basic_frames();
		send_rx_byte(8'h00);
		send_rx_byte(8'hFE);
		send_frame(tag_cfg, 5, FRAME_OK, 1'b0);
		send_frame(tag_cfg, 6, FRAME_OK, 1'b1);
		send_frame(tag_cfg ^ 8'h80, 9, FRAME_OK, 1'b0);
	endtask

	task automatic test_bad_frames();
		send_bad_length(tag_cfg, 8'd4);
		send_bad_length(tag_cfg, 8'd0);
		send_bad_length(tag_cfg, 8'd17);
		send_bad_length(tag_cfg, 8'hFF);
		send_frame(tag_cfg, 5, FRAME_OK, 1'b0);
		send_frame(tag_cfg, 7, FRAME_BAD_CRC, 1'b0);
		send_frame(tag_cfg, 5, FRAME_OK, 1'b0);
	endtask

	task automatic test_config_extremes();
		set_config(16'h0000, 8'h00, 6'd0);
		send_frame(8'h00, 5, FRAME_OK, 1'b0);
		send_bad_length(8'h00, 8'd6);
		send_frame(8'hFF, 5, FRAME_OK, 1'b0);
		set_config(16'hFFFF, 8'hFF, 6'd59);
		send_frame(8'hFF, 16, FRAME_OK, 1'b1);
		send_bad_length(8'hFF, 8'd17);
		send_frame(8'h00, 16, FRAME_OK, 1'b0);
	endtask

	task automatic test_seed_mid_frame();
		logic [7:0]  fb [0:6];
		logic [15:0] crc;
		int          i;
		fb[0] = HDR_BYTE;
		fb[1] = tag_cfg;
		fb[2] = 8'd7;
		fb[3] = 8'($urandom);
		fb[4] = 8'($urandom);
		crc = seed_cfg;
		for (i = 0; i < 5; i++)
			crc = crc16_step(crc, fb[i]);
		fb[5] = crc[15:8];
		fb[6] = crc[7:0];
		send_rx_byte(fb[0]);
		send_rx_byte(fb[1]);
		write_reg(REG_CRC_SEED, 32'h0000_1D0F);
		for (i = 2; i < 7; i++)
			send_rx_byte(fb[i]);
		send_frame(tag_cfg, 8, FRAME_OK, 1'b0);
	endtask

	task automatic test_back_pressure();
		settle();
		sink_hold = 300;
		send_frame(tag_cfg, 16, FRAME_OK, 1'b0);
		send_frame(tag_cfg, 16, FRAME_OK, 1'b0);
		send_frame(8'h5A, 12, FRAME_OK, 1'b0);
		send_frame(tag_cfg, 5, FRAME_OK, 1'b0);
	endtask

	task automatic test_random_stream(input int n_items);
		int         counted;
		int         pick;
		int         len_top;
		int         len;
		int         i;
		logic [7:0] tag;
		counted = 0;
		len_top = (int'(maxv_cfg) + 5 < STORE_DEPTH) ? int'(maxv_cfg) + 5 : STORE_DEPTH;
		while (counted < n_items) begin
			pick = $urandom_range(0, 99);
			tag = ($urandom_range(0, 3) == 0) ? tag_cfg : 8'($urandom);
			len = $urandom_range(5, len_top);
			if (pick < 68) begin
				send_frame(tag, len, FRAME_OK, $urandom_range(0, 5) == 0);
				counted += len;
			end else if (pick < 78) begin
				send_frame(tag, len, FRAME_BAD_CRC, 1'b0);
				counted += len;
			end else if (pick < 84) begin
				send_frame(tag, len, FRAME_CUT, 1'b0);
				counted += 3;
			end else if (pick < 92) begin
				if ($urandom_range(0, 1) == 0)
					send_bad_length(tag, 8'($urandom_range(0, 4)));
				else
					send_bad_length(tag, 8'($urandom_range(len_top + 1, 255)));
				counted += 3;
			end else begin
				for (i = 0; i < $urandom_range(1, 4); i++)
					send_rx_byte(8'($urandom_range(0, 254)));
			end
		end
		flush_parser();
	endtask

	task automatic finish_run();
		settle();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("tlv_frame_crc_parser_unit verification clean");
		else
			$display("tlv_frame_crc_parser_unit verification failed");
		$finish;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_frames();
		test_bad_frames();
		test_config_extremes();
		test_seed_mid_frame();
		test_back_pressure();
		set_config(CRC_SEED_RST, ACCEPTED_TAG_RST, MAX_VALUE_LEN_RST);
		test_random_stream(8);
		set_config(16'($urandom), 8'($urandom), 6'($urandom_range(0, 59)));
		test_random_stream(8);
		set_config(16'($urandom), 8'($urandom), 6'($urandom_range(6, 59)));
		test_random_stream(8);
		set_config(16'($urandom), 8'($urandom), 6'($urandom_range(0, 59)));
		src_gaps_on = 1'b0;
		sink_gaps_on = 1'b0;
		test_random_stream(8);
		finish_run();
	end

endmodule
